// ===== hw/rtl/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types, opcodes, status codes and the microcode program of the
// stack-machine ALU.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DATA_W          = 32;
  localparam int CMD_W           = 4;
  localparam int DEPTH_OUT_W     = 7;
  localparam int DIV_CNT_W       = 5;

  // opcodes; the two codes above OP_SWAP are illegal
  typedef enum logic [CMD_W-1:0] {
    OP_CLR  = 4'd0,
    OP_HALT = 4'd1,
    OP_NEG  = 4'd2,
    OP_DUP  = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_LDC  = 4'd8,
    OP_INP  = 4'd9,
    OP_OUT  = 4'd10,
    OP_DBG  = 4'd11,
    OP_TRA  = 4'd12,
    OP_SWAP = 4'd13
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OUT   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_OVF   = 3'd4,
    ST_HALT  = 3'd5,
    ST_ILL   = 3'd6
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] operand_value;
  } instr_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] out_value;
    logic [DEPTH_OUT_W-1:0]   stack_depth;
  } result_t;

  // microcode addresses
  typedef enum logic [4:0] {
    U_FETCH = 5'd0,
    U_READ,
    U_DISP,
    U_CLR,
    U_NEG,
    U_DUP,
    U_ADD,
    U_SUB,
    U_MUL,
    U_MULW,
    U_DIV,
    U_DIVL,
    U_DIVW,
    U_PUSH,
    U_OUT,
    U_NOP,
    U_SWAP,
    U_SWAP2,
    U_HALT,
    U_EMPTY,
    U_DIVZ,
    U_OVF,
    U_ILL
  } upc_t;

  typedef enum logic [1:0] {
    J_NEXT,   // go to nxt
    J_IN,     // go to nxt once a beat is taken
    J_DISP,   // opcode dispatch
    J_CNT     // repeat until the iteration count runs out, then nxt
  } jmp_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_TOP,    // entry sp-1
    W_SEC,    // entry sp-2
    W_PUSH    // entry sp
  } wsel_t;

  typedef enum logic [2:0] {
    D_NEG,
    D_A,
    D_B,
    D_OPND,
    D_SUM,
    D_DIFF,
    D_RES,
    D_QUO
  } dsel_t;

  typedef enum logic [1:0] {
    SP_KEEP,
    SP_INC,
    SP_DEC,
    SP_ZERO
  } spop_t;

  typedef struct packed {
    jmp_t    jmp;
    upc_t    nxt;
    wsel_t   wsel;
    dsel_t   dsel;
    spop_t   spop;
    logic    ld_ab;
    logic    mul;
    logic    div_init;
    logic    div_step;
    logic    fin;
    status_t sts;
    logic    set_halt;
    logic    oval;
  } ucw_t;

  // control store
  function automatic ucw_t ucode(upc_t u);
    ucw_t w;
    w = '0;
    w.nxt = U_FETCH;
    unique case (u)
      U_FETCH: begin
        w.jmp = J_IN;
        w.nxt = U_READ;
      end
      U_READ:  w.nxt = U_DISP;
      U_DISP: begin
        w.jmp   = J_DISP;
        w.ld_ab = 1'b1;
      end
      U_CLR: begin
        w.fin  = 1'b1;
        w.spop = SP_ZERO;
      end
      U_NEG: begin
        w.fin  = 1'b1;
        w.wsel = W_TOP;
        w.dsel = D_NEG;
      end
      U_DUP: begin
        w.fin  = 1'b1;
        w.wsel = W_PUSH;
        w.dsel = D_A;
        w.spop = SP_INC;
      end
      U_ADD: begin
        w.fin  = 1'b1;
        w.wsel = W_SEC;
        w.dsel = D_SUM;
        w.spop = SP_DEC;
      end
      U_SUB: begin
        w.fin  = 1'b1;
        w.wsel = W_SEC;
        w.dsel = D_DIFF;
        w.spop = SP_DEC;
      end
      U_MUL: begin
        w.mul = 1'b1;
        w.nxt = U_MULW;
      end
      U_MULW: begin
        w.fin  = 1'b1;
        w.wsel = W_SEC;
        w.dsel = D_RES;
        w.spop = SP_DEC;
      end
      U_DIV: begin
        w.div_init = 1'b1;
        w.nxt      = U_DIVL;
      end
      U_DIVL: begin
        w.jmp      = J_CNT;
        w.div_step = 1'b1;
        w.nxt      = U_DIVW;
      end
      U_DIVW: begin
        w.fin  = 1'b1;
        w.wsel = W_SEC;
        w.dsel = D_QUO;
        w.spop = SP_DEC;
      end
      U_PUSH: begin
        w.fin  = 1'b1;
        w.wsel = W_PUSH;
        w.dsel = D_OPND;
        w.spop = SP_INC;
      end
      U_OUT: begin
        w.fin  = 1'b1;
        w.spop = SP_DEC;
        w.oval = 1'b1;
        w.sts  = ST_OUT;
      end
      U_NOP:   w.fin = 1'b1;
      U_SWAP: begin
        w.wsel = W_TOP;
        w.dsel = D_B;
        w.nxt  = U_SWAP2;
      end
      U_SWAP2: begin
        w.fin  = 1'b1;
        w.wsel = W_SEC;
        w.dsel = D_A;
      end
      U_HALT: begin
        w.fin      = 1'b1;
        w.set_halt = 1'b1;
        w.sts      = ST_HALT;
      end
      U_EMPTY: begin
        w.fin      = 1'b1;
        w.set_halt = 1'b1;
        w.sts      = ST_EMPTY;
      end
      U_DIVZ: begin
        w.fin      = 1'b1;
        w.set_halt = 1'b1;
        w.sts      = ST_DIVZ;
      end
      U_OVF: begin
        w.fin      = 1'b1;
        w.set_halt = 1'b1;
        w.sts      = ST_OVF;
      end
      U_ILL: begin
        w.fin      = 1'b1;
        w.set_halt = 1'b1;
        w.sts      = ST_ILL;
      end
      default: w.nxt = U_FETCH;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/sma_ram.sv =====
// ----------------------------------------------------------------------------
// sma_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== hw/rtl/stack_machine_alu_unit.sv =====
// Each instruction runs the fetch, read and dispatch microsteps, then its own
// steps; multiply and swap end in U_MULW or U_SWAP2, and divide, the slowest,
// runs 32 quotient-bit iterations in U_DIVL. The microcode sequencer handles
// one instruction at a time and takes a new beat only in the fetch step.
// Reset clears the sequencer, stack pointer, halted flag and result valid;
// stack memory contents are not cleared.
// ----------------------------------------------------------------------------
// stack_machine_alu_unit
// Microcoded stack-machine executor: control store drives a datapath with
// a stack RAM, adder, multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module stack_machine_alu_unit #(
  parameter int STACK_DEPTH = sma_pkg::DEF_STACK_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  sma_pkg::instr_t  instr,
  output logic             result_valid,
  input  logic             result_stall,
  output sma_pkg::result_t result
);

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int DW   = sma_pkg::DATA_W;
  localparam int OW   = sma_pkg::DEPTH_OUT_W;
  localparam int CW   = sma_pkg::DIV_CNT_W;

  sma_pkg::upc_t upc, upc_next, disp_upc;
  sma_pkg::ucw_t cw;

  logic                     accept, go, ram_we;
  logic [sma_pkg::CMD_W-1:0] cmd_q;
  logic [DW-1:0]            opnd_q;
  logic [SP_W-1:0]          sp, sp_next, sp_m1, sp_m2;
  logic                     halted;
  logic [DW-1:0]            a, b, res, rd_top, rd_sec, wdata, prod_lo;
  logic [AW-1:0]            waddr;
  logic [DW-1:0]            dq, dr, dd, quo_final, mag_a, mag_b;
  logic                     dneg;
  logic [CW-1:0]            cnt;
  logic [DW:0]              rem_sh, trial;
  logic [SP_W+OW-1:0]       depth_ext;

  assign cw          = sma_pkg::ucode(upc);
  assign instr_stall = (upc != sma_pkg::U_FETCH);
  assign accept      = instr_valid && !instr_stall;
  // a finishing step waits while the previous result is still held
  assign go          = !cw.fin || !result_valid || !result_stall;

  assign sp_m1 = sp - SP_W'(1);
  assign sp_m2 = sp - SP_W'(2);

  sma_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (sp_m1[AW-1:0]),
    .rdata0 (rd_top),
    .raddr1 (sp_m2[AW-1:0]),
    .rdata1 (rd_sec)
  );

  // datapath
  assign prod_lo   = a * b;
  assign mag_a     = a[DW-1] ? (DW'(0) - a) : a;
  assign mag_b     = b[DW-1] ? (DW'(0) - b) : b;
  assign rem_sh    = {dr, dq[DW-1]};
  assign trial     = rem_sh - {1'b0, dd};
  assign quo_final = dneg ? (DW'(0) - dq) : dq;

  always_comb begin
    unique case (cw.dsel)
      sma_pkg::D_NEG:  wdata = DW'(0) - a;
      sma_pkg::D_A:    wdata = a;
      sma_pkg::D_B:    wdata = b;
      sma_pkg::D_OPND: wdata = opnd_q;
      sma_pkg::D_SUM:  wdata = a + b;
      sma_pkg::D_DIFF: wdata = a - b;
      sma_pkg::D_RES:  wdata = res;
      sma_pkg::D_QUO:  wdata = quo_final;
      default:         wdata = a;
    endcase
  end

  always_comb begin
    ram_we = go && (cw.wsel != sma_pkg::W_NONE);
    unique case (cw.wsel)
      sma_pkg::W_TOP:  waddr = sp_m1[AW-1:0];
      sma_pkg::W_SEC:  waddr = sp_m2[AW-1:0];
      sma_pkg::W_PUSH: waddr = sp[AW-1:0];
      default:         waddr = sp[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cw.spop)
      sma_pkg::SP_INC:  sp_next = sp + SP_W'(1);
      sma_pkg::SP_DEC:  sp_next = sp_m1;
      sma_pkg::SP_ZERO: sp_next = '0;
      default:          sp_next = sp;
    endcase
  end
  assign depth_ext = {{OW{1'b0}}, sp_next};

  // opcode dispatch with halt, stack and divide-by-zero checks
  always_comb begin
    disp_upc = sma_pkg::U_ILL;
    if (halted) begin
      disp_upc = sma_pkg::U_HALT;
    end else begin
      unique case (cmd_q)
        sma_pkg::OP_CLR:  disp_upc = sma_pkg::U_CLR;
        sma_pkg::OP_HALT: disp_upc = sma_pkg::U_HALT;
        sma_pkg::OP_NEG:
          disp_upc = (sp == '0) ? sma_pkg::U_EMPTY : sma_pkg::U_NEG;
        sma_pkg::OP_DUP: begin
          priority if (sp == '0)                   disp_upc = sma_pkg::U_EMPTY;
          else if (sp == SP_W'(STACK_DEPTH))       disp_upc = sma_pkg::U_OVF;
          else                                     disp_upc = sma_pkg::U_DUP;
        end
        sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV,
        sma_pkg::OP_SWAP: begin
          priority if (sp == '0 || sp == SP_W'(1)) disp_upc = sma_pkg::U_EMPTY;
          else if (cmd_q == sma_pkg::OP_ADD)       disp_upc = sma_pkg::U_ADD;
          else if (cmd_q == sma_pkg::OP_SUB)       disp_upc = sma_pkg::U_SUB;
          else if (cmd_q == sma_pkg::OP_MUL)       disp_upc = sma_pkg::U_MUL;
          else if (cmd_q == sma_pkg::OP_SWAP)      disp_upc = sma_pkg::U_SWAP;
          else if (rd_sec == '0)                   disp_upc = sma_pkg::U_DIVZ;
          else                                     disp_upc = sma_pkg::U_DIV;
        end
        sma_pkg::OP_LDC, sma_pkg::OP_INP:
          disp_upc = (sp == SP_W'(STACK_DEPTH)) ? sma_pkg::U_OVF : sma_pkg::U_PUSH;
        sma_pkg::OP_OUT:
          disp_upc = (sp == '0) ? sma_pkg::U_EMPTY : sma_pkg::U_OUT;
        sma_pkg::OP_DBG, sma_pkg::OP_TRA: disp_upc = sma_pkg::U_NOP;
        default: disp_upc = sma_pkg::U_ILL;
      endcase
    end
  end

  // sequencer
  always_comb begin
    upc_next = upc;
    if (go) begin
      unique case (cw.jmp)
        sma_pkg::J_NEXT: upc_next = cw.nxt;
        sma_pkg::J_IN:   upc_next = accept ? cw.nxt : upc;
        sma_pkg::J_DISP: upc_next = disp_upc;
        sma_pkg::J_CNT:  upc_next = (cnt != '0) ? upc : cw.nxt;
        default:         upc_next = sma_pkg::U_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc          <= sma_pkg::U_FETCH;
      sp           <= '0;
      halted       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (go) begin
        sp <= sp_next;
      end
      if (go && cw.set_halt) begin
        halted <= 1'b1;
      end
      if (go && cw.fin) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= instr.command;
      opnd_q <= instr.operand_value;
    end
    if (cw.ld_ab) begin
      a <= rd_top;
      b <= rd_sec;
    end
    if (cw.mul) begin
      res <= prod_lo;
    end
    if (cw.div_init) begin
      dq   <= mag_a;
      dr   <= '0;
      dd   <= mag_b;
      dneg <= a[DW-1] ^ b[DW-1];
      cnt  <= '1;
    end else if (cw.div_step) begin
      cnt <= cnt - CW'(1);
      if (!trial[DW]) begin
        dr <= trial[DW-1:0];
        dq <= {dq[DW-2:0], 1'b1};
      end else begin
        dr <= rem_sh[DW-1:0];
        dq <= {dq[DW-2:0], 1'b0};
      end
    end
    if (go && cw.fin) begin
      result.status      <= cw.sts;
      result.out_value   <= cw.oval ? a : '0;
      result.stack_depth <= depth_ext[OW-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_halt_freeze: assert property (@(posedge clk) disable iff (rst)
    halted |=> $stable(sp) && halted)
    else $error("stack changed after halt");

  a_halt_status: assert property (@(posedge clk) disable iff (rst)
    (go && cw.fin && halted) |-> (cw.sts == sma_pkg::ST_HALT))
    else $error("non-halt status while halted");

  a_out_pop: assert property (@(posedge clk) disable iff (rst)
    (go && cw.fin && cw.sts == sma_pkg::ST_OUT) |=> (sp == $past(sp) - SP_W'(1)))
    else $error("output did not pop the stack");
`endif

endmodule

// ===== sim/stack_machine_alu_checker.sv =====
// ----------------------------------------------------------------------------
// stack_machine_alu_checker
// Watches the instruction and result channels of the stack-machine ALU. It
// keeps its own copy of the stack, the depth and the halted flag, works out
// the expected result of every accepted instruction beat, and compares each
// result beat field by field with the oldest expected result. The predicted
// depth and second entry are exported so that stimulus can steer clear of
// errors.
// ----------------------------------------------------------------------------
module stack_machine_alu_checker #(
  parameter int STACK_DEPTH = sma_pkg::DEF_STACK_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       instr_valid,
  input  logic                       instr_stall,
  input  sma_pkg::instr_t            instr,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  sma_pkg::result_t           result,
  output int                         stack_level,
  output logic [sma_pkg::DATA_W-1:0] second_entry,
  output int                         results_due,
  output int                         mismatches
);
  import sma_pkg::*;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  bit                machine_halted;
  result_t           pending_results [$];

  assign second_entry = (stack_level >= 2) ? stack_mem[stack_level-2] : '0;

  // executes one instruction on the shadow stack and returns its result
  function automatic result_t execute(input instr_t ins);
    result_t           r;
    logic [DATA_W-1:0] a, b, ma, mb, q;
    int                need;
    r.status    = ST_OK;
    r.out_value = '0;
    if (machine_halted) begin
      r.status = ST_HALT;
    end else begin
      case (ins.command)
        OP_NEG, OP_DUP, OP_OUT: need = 1;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: need = 2;
        default: need = 0;
      endcase
      a = (stack_level >= 1) ? stack_mem[stack_level-1] : '0;
      b = (stack_level >= 2) ? stack_mem[stack_level-2] : '0;
      if (stack_level < need) begin
        r.status = ST_EMPTY;
      end else begin
        case (ins.command)
          OP_CLR:  stack_level = 0;
          OP_HALT: r.status = ST_HALT;
          OP_NEG:  stack_mem[stack_level-1] = 32'd0 - a;
          OP_DUP, OP_LDC, OP_INP: begin
            if (stack_level >= STACK_DEPTH) begin
              r.status = ST_OVF;
            end else begin
              stack_mem[stack_level] = (ins.command == OP_DUP) ? a : ins.operand_value;
              stack_level++;
            end
          end
          OP_ADD: begin
            stack_mem[stack_level-2] = a + b;
            stack_level--;
          end
          OP_SUB: begin
            stack_mem[stack_level-2] = a - b;
            stack_level--;
          end
          OP_MUL: begin
            stack_mem[stack_level-2] = a * b;
            stack_level--;
          end
          OP_DIV: begin
            if (b == '0) begin
              r.status = ST_DIVZ;
            end else begin
              // magnitudes, then sign: truncates toward zero
              ma = a[DATA_W-1] ? 32'd0 - a : a;
              mb = b[DATA_W-1] ? 32'd0 - b : b;
              q  = ma / mb;
              stack_mem[stack_level-2] = (a[DATA_W-1] != b[DATA_W-1]) ? 32'd0 - q : q;
              stack_level--;
            end
          end
          OP_OUT: begin
            r.out_value = a;
            r.status    = ST_OUT;
            stack_level--;
          end
          OP_DBG, OP_TRA: ;
          OP_SWAP: begin
            stack_mem[stack_level-1] = b;
            stack_mem[stack_level-2] = a;
          end
          default: r.status = ST_ILL;
        endcase
      end
      if (r.status != ST_OK && r.status != ST_OUT) machine_halted = 1'b1;
    end
    r.stack_depth = stack_level[DEPTH_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stack_level    = 0;
      machine_halted = 1'b0;
      mismatches     = 0;
      pending_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no instruction outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            mismatches++;
          end
          if (result.out_value !== want.out_value) begin
            $error("out_value: expected %0d, actual %0d", want.out_value, result.out_value);
            mismatches++;
          end
          if (result.stack_depth !== want.stack_depth) begin
            $error("stack_depth: expected %0d, actual %0d",
                   want.stack_depth, result.stack_depth);
            mismatches++;
          end
        end
      end
      if (instr_valid && !instr_stall) pending_results.push_back(execute(instr));
    end
    results_due = pending_results.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the stack-machine ALU with a directed program covering the value
// extremes and every opcode but halt, then 950 random instructions that never
// trip an error, steered by the checker's view of the stack. The run closes
// with one randomly chosen halting event (halt, too few entries, divide by
// zero, full stack or illegal opcode) and a few instructions sent while
// halted. Sender gaps and receiver stalls vary by phase, with long receiver
// holds so the block backs up.
// ----------------------------------------------------------------------------
module testbench;
  import sma_pkg::*;

  localparam int STACK_DEPTH  = DEF_STACK_DEPTH;
  localparam int RANDOM_ITEMS = 950;
  localparam int CHUNK        = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 800000;

  localparam logic [CMD_W-1:0] OP_BAD_LO = 4'd14;
  localparam logic [CMD_W-1:0] OP_BAD_HI = 4'd15;

  // every ending leaves the machine halted for good
  typedef enum int {END_HALT, END_EMPTY, END_DIVZ, END_OVF, END_ILL} ending_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    instr_valid  = 1'b0;
  logic    instr_stall;
  instr_t  instr        = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int                stack_level;
  logic [DATA_W-1:0] second_entry;
  int                results_due;
  int                mismatches;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  always #1 clk = ~clk;

  stack_machine_alu_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  stack_machine_alu_checker #(.STACK_DEPTH(STACK_DEPTH)) alu_check (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .stack_level  (stack_level),
    .second_entry (second_entry),
    .results_due  (results_due),
    .mismatches   (mismatches)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stack_machine_alu_unit verification failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    logic stall_next;
    if (hold_served < hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      stall_next = ($urandom_range(99) < stall_pct);
    end
    result_stall <= stall_next;
  end

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      4, 5: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // offers one instruction beat, returns at the falling edge after it is taken
  task automatic send_instr(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] opnd);
    while ($urandom_range(99) < idle_pct) begin
      instr_valid <= 1'b0;
      @(negedge clk);
    end
    instr_valid <= 1'b1;
    instr       <= '{command: cmd, operand_value: opnd};
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    logic             ok;
    int               roll;
    int               push_weight;
    ending_t          ending;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed program: wraps, extremes, every opcode but halt
    send_instr(OP_LDC, 32'h7fff_ffff);
    send_instr(OP_LDC, 32'd1);
    send_instr(OP_ADD, $urandom);        // wraps to -2^31
    send_instr(OP_DUP, $urandom);
    send_instr(OP_NEG, $urandom);        // -2^31 stays -2^31
    send_instr(OP_MUL, $urandom);        // low word of 2^62 is zero
    send_instr(OP_OUT, $urandom);
    send_instr(OP_INP, 32'hffff_ffff);
    send_instr(OP_INP, 32'h8000_0000);
    send_instr(OP_DIV, $urandom);        // -2^31 / -1
    send_instr(OP_LDC, 32'd2);
    send_instr(OP_LDC, -32'sd7);
    send_instr(OP_DIV, $urandom);        // -7 / 2 truncates to -3
    send_instr(OP_SUB, $urandom);
    send_instr(OP_LDC, 32'h1234_5678);
    send_instr(OP_SWAP, $urandom);
    send_instr(OP_DBG, $urandom);
    send_instr(OP_TRA, $urandom);
    send_instr(OP_OUT, $urandom);
    send_instr(OP_OUT, $urandom);
    send_instr(OP_LDC, 32'd5);
    send_instr(OP_CLR, $urandom);

    push_weight = 40;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % CHUNK == 0) begin
        case ((n / CHUNK) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 75; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 75; end
          default: begin idle_pct = 21; stall_pct = 21; end
        endcase
        case ($urandom_range(2))
          0: push_weight = 20;
          1: push_weight = 40;
          default: push_weight = 95;   // climbs to a full stack and stays near it
        endcase
        if (n / CHUNK == 4 || n / CHUNK == 12) hold_requests++;
      end
      do begin
        roll = $urandom_range(push_weight + 59);
        if (roll < push_weight) begin
          cmd = $urandom_range(1) ? OP_LDC : OP_INP;
        end else begin
          case ($urandom_range(11))
            0: cmd = OP_NEG;
            1: cmd = OP_DUP;
            2: cmd = OP_ADD;
            3: cmd = OP_SUB;
            4: cmd = OP_MUL;
            5: cmd = OP_DIV;
            6, 7: cmd = OP_OUT;
            8: cmd = OP_SWAP;
            9: cmd = OP_DBG;
            10: cmd = OP_TRA;
            default: cmd = OP_CLR;
          endcase
        end
        ok = 1'b1;
        case (cmd)
          OP_NEG, OP_DUP, OP_OUT: ok = (stack_level >= 1);
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: ok = (stack_level >= 2);
          default: ;
        endcase
        if ((cmd == OP_DUP || cmd == OP_LDC || cmd == OP_INP) && stack_level >= STACK_DEPTH)
          ok = 1'b0;
        if (cmd == OP_DIV && second_entry == '0) ok = 1'b0;
        if (cmd == OP_CLR && $urandom_range(3) != 0) ok = 1'b0;
      end while (!ok);
      send_instr(cmd, rand_word());
    end

    idle_pct  = 21;
    stall_pct = 21;
    ending = ending_t'($urandom_range(END_ILL));
    case (ending)
      END_HALT: send_instr(OP_HALT, $urandom);
      END_EMPTY: begin
        send_instr(OP_CLR, $urandom);
        case ($urandom_range(3))
          0: send_instr(OP_OUT, $urandom);
          1: send_instr(OP_NEG, $urandom);
          2: begin
            send_instr(OP_LDC, rand_word());
            send_instr(OP_SWAP, $urandom);
          end
          default: send_instr(OP_DIV, $urandom);
        endcase
      end
      END_DIVZ: begin
        while (stack_level > STACK_DEPTH - 2) send_instr(OP_OUT, $urandom);
        send_instr(OP_LDC, '0);
        send_instr(OP_LDC, rand_word());
        send_instr(OP_DIV, $urandom);
      end
      END_OVF: begin
        while (stack_level < STACK_DEPTH)
          send_instr($urandom_range(1) ? OP_LDC : OP_INP, rand_word());
        case ($urandom_range(2))
          0: send_instr(OP_DUP, $urandom);
          1: send_instr(OP_LDC, rand_word());
          default: send_instr(OP_INP, rand_word());
        endcase
      end
      default: send_instr($urandom_range(1) ? OP_BAD_HI : OP_BAD_LO, $urandom);
    endcase

    // halted: the block answers everything after this with halt status only
    repeat (12) send_instr(CMD_W'($urandom_range(15)), $urandom);
    instr_valid <= 1'b0;

    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("stack_machine_alu_unit verification clean");
    else
      $display("stack_machine_alu_unit verification failed");
    $finish;
  end

endmodule
